### hdl/iem_pkg.sv
package iem_pkg;

	// Register indexes on the configuration port (byte address = 8 * index)
	localparam logic [2:0] REG_FAMILY   = 3'd0;
	localparam logic [2:0] REG_IDENT    = 3'd1;
	localparam logic [2:0] REG_SEQUENCE = 3'd2;
	localparam logic [2:0] REG_DEST_HI  = 3'd3;
	localparam logic [2:0] REG_DEST_LO  = 3'd4;

	localparam int unsigned APB_ADDR_W = 6;
	localparam int unsigned APB_DATA_W = 64;

	// ICMP message types of an echo reply, and the IPv4 protocol number of ICMP
	localparam logic [7:0] ICMP4_ECHO_REPLY  = 8'd0;
	localparam logic [7:0] ICMPV6_REPLY_TYPE = 8'd129;
	localparam logic [7:0] IP_PROTO_ICMP     = 8'd1;

	// Byte offsets inside the IPv4 header and the ICMP message
	localparam logic [6:0] OFS_PROTOCOL  = 7'd9;
	localparam logic [6:0] OFS_ID_HI     = 7'd4;
	localparam logic [6:0] OFS_ID_LO     = 7'd5;
	localparam logic [6:0] OFS_SEQ_HI    = 7'd6;
	localparam logic [6:0] OFS_SEQ_LO    = 7'd7;
	localparam logic [6:0] POS_MAX       = 7'd127;
	localparam logic [5:0] MIN_IPV4_HDR  = 6'd20;

	// Per-packet parse state
	typedef struct packed {
		logic [6:0] byte_position;
		logic [5:0] header_bytes;
		logic       protocol_ok;
		logic       type_ok;
		logic       ident_ok;
		logic       sequence_ok;
		logic       sender_ok;
	} pkt_state_t;

	localparam pkt_state_t PKT_STATE_CLEAR = '{
		byte_position: 7'd0,
		header_bytes:  6'd0,
		protocol_ok:   1'b0,
		type_ok:       1'b0,
		ident_ok:      1'b1,
		sequence_ok:   1'b1,
		sender_ok:     1'b0
	};

endpackage

### hdl/icmp_echo_reply_matcher.sv
// ICMP echo reply matcher.
// Input channel (in_valid/in_ready): one packet byte per word, with last_byte
// marking the final byte and the sender family/address taken on the first byte.
// Output channel (out_valid/out_ready): one word per packet, matched = 1 when
// the packet is the awaited echo reply (IPv4 with header, or bare ICMPv6).
// Configuration: APB-style port, 64-bit data, register i at byte address 8*i
// (family_v6, echo_identifier, echo_sequence, dest_addr_high, dest_addr_low).
// Throughput: one byte per cycle, unless a last byte waits for the output slot. A byte
// is registered at acceptance and parsed from that register; the result of a last byte
// enters the output register as that byte leaves the input register.
// The input register and the output register are separate, so bytes keep
// flowing while a result waits; only a last byte waits for a free output slot.
// When the receiver stalls with a result pending and another last byte
// arrives, in_ready drops until the pending result is taken.
// Reset clears the configuration registers to zero and the parse state to the
// start of a packet; no result is pending after reset.
module icmp_echo_reply_matcher (
	input  logic                               clk,
	input  logic                               arst_n,
	// packet byte channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         packet_byte,
	input  logic                               last_byte,
	input  logic                               from_is_v6,
	input  logic [63:0]                        from_addr_high,
	input  logic [63:0]                        from_addr_low,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               matched,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [iem_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [iem_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [iem_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import iem_pkg::*;

	logic        family_v6_q;
	logic [15:0] echo_identifier_q;
	logic [15:0] echo_sequence_q;
	logic [63:0] dest_addr_high_q;
	logic [63:0] dest_addr_low_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        from_v6_s1;
	logic [63:0] from_hi_s1;
	logic [63:0] from_lo_s1;

	pkt_state_t  st_q;
	pkt_state_t  st_cur;
	pkt_state_t  st_next;
	logic        adv_s1;
	logic        match_now;
	logic        addr_eq;
	logic [6:0]  off;
	logic [6:0]  hdr_ext;

	logic        out_valid_q;
	logic        matched_q;
	logic        cfg_wr;

	// configuration writes and reads
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			family_v6_q         <= 1'b0;
			echo_identifier_q   <= 16'd0;
			echo_sequence_q     <= 16'd0;
			dest_addr_high_q    <= 64'd0;
			dest_addr_low_q     <= 64'd0;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				REG_FAMILY:   family_v6_q         <= pwdata[0];
				REG_IDENT:    echo_identifier_q   <= pwdata[15:0];
				REG_SEQUENCE: echo_sequence_q     <= pwdata[15:0];
				REG_DEST_HI:  dest_addr_high_q    <= pwdata;
				REG_DEST_LO:  dest_addr_low_q     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			REG_FAMILY:   prdata = {63'd0, family_v6_q};
			REG_IDENT:    prdata = {48'd0, echo_identifier_q};
			REG_SEQUENCE: prdata = {48'd0, echo_sequence_q};
			REG_DEST_HI:  prdata = dest_addr_high_q;
			REG_DEST_LO:  prdata = dest_addr_low_q;
			default:      prdata = '0;
		endcase
	end

	// advance the input register when its byte can be parsed this cycle
	assign adv_s1   = valid_s1 & (~last_s1 | ~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready & in_valid) begin
			byte_s1    <= packet_byte;
			last_s1    <= last_byte;
			from_v6_s1 <= from_is_v6;
			from_hi_s1 <= from_addr_high;
			from_lo_s1 <= from_addr_low;
		end
	end

	// parse one byte against the packet state
	always_comb begin
		if (family_v6_q) begin
			addr_eq = (from_hi_s1 == dest_addr_high_q) && (from_lo_s1 == dest_addr_low_q);
		end else begin
			addr_eq = (from_lo_s1[31:0] == dest_addr_low_q[31:0]);
		end

		st_cur = st_q;
		if (st_q.byte_position == 7'd0) begin
			st_cur              = PKT_STATE_CLEAR;
			st_cur.sender_ok    = (from_v6_s1 == family_v6_q) && addr_eq;
			st_cur.header_bytes = {byte_s1[3:0], 2'b00};
		end

		hdr_ext = {1'b0, st_cur.header_bytes};
		off     = family_v6_q ? 7'd0 : hdr_ext;
		st_next = st_cur;

		if (!family_v6_q && st_cur.byte_position == OFS_PROTOCOL) begin
			st_next.protocol_ok = (byte_s1 == IP_PROTO_ICMP);
		end
		if (st_cur.byte_position == off) begin
			st_next.type_ok = (byte_s1 ==
			                   (family_v6_q ? ICMPV6_REPLY_TYPE : ICMP4_ECHO_REPLY));
		end
		if (st_cur.byte_position == off + OFS_ID_HI && byte_s1 != echo_identifier_q[15:8]) begin
			st_next.ident_ok = 1'b0;
		end
		if (st_cur.byte_position == off + OFS_ID_LO && byte_s1 != echo_identifier_q[7:0]) begin
			st_next.ident_ok = 1'b0;
		end
		if (st_cur.byte_position == off + OFS_SEQ_HI &&
		    byte_s1 != echo_sequence_q[15:8]) begin
			st_next.sequence_ok = 1'b0;
		end
		if (st_cur.byte_position == off + OFS_SEQ_LO &&
		    byte_s1 != echo_sequence_q[7:0]) begin
			st_next.sequence_ok = 1'b0;
		end

		if (family_v6_q) begin
			match_now = st_next.sender_ok && (st_cur.byte_position >= OFS_SEQ_LO) &&
			            st_next.type_ok && st_next.ident_ok && st_next.sequence_ok;
		end else begin
			match_now = st_next.sender_ok && st_next.protocol_ok &&
			            (st_cur.header_bytes >= MIN_IPV4_HDR) &&
			            (st_cur.byte_position >= hdr_ext + OFS_SEQ_LO) &&
			            st_next.type_ok && st_next.ident_ok && st_next.sequence_ok;
		end

		// drop the packet state at the last byte, else advance the saturating count
		if (last_s1) begin
			st_next = PKT_STATE_CLEAR;
		end else if (st_cur.byte_position != POS_MAX) begin
			st_next.byte_position = st_cur.byte_position + 7'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PKT_STATE_CLEAR;
		end else if (adv_s1) begin
			st_q <= st_next;
		end
	end

	// hold the result word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 & last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 & last_s1) begin
			matched_q <= match_now;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;

`ifndef SYNTH
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> out_valid_q)
		else $error("last byte parsed without a result word");

	a_last_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> st_q.byte_position == 7'd0)
		else $error("byte count not cleared after last byte");

	a_count_advances: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !last_s1 && st_q.byte_position != POS_MAX
		|=> st_q.byte_position == $past(st_q.byte_position) + 7'd1)
		else $error("byte count did not advance");

	a_empty_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("empty input register refuses a word");

	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> last_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a pending result");
`endif

endmodule

### dv/tb_icmp_echo_reply_matcher.sv
`timescale 1ns / 100ps

module tb_icmp_echo_reply_matcher;
	import iem_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BYTES = 1400;
	localparam int HOLD_CYCLES  = 300;
	localparam int IHL_UNIT     = 4;

	typedef bit [7:0] byte_seq_t[$];

	// Verdict predictor: parses each accepted word and queues the expected match bit at each last word
	class echo_reply_scoreboard;
		bit        cfg_v6;
		bit [15:0] cfg_ident;
		bit [15:0] cfg_seq;
		bit [63:0] cfg_dest_hi;
		bit [63:0] cfg_dest_lo;
		bit [6:0]  pos;
		bit [5:0]  hdr_len;
		bit        proto_ok;
		bit        type_ok;
		bit        id_ok;
		bit        seq_ok;
		bit        from_ok;
		bit        verdict_q[$];
		int        errors;

		function new();
			cfg_v6      = 1'b0;
			cfg_ident   = '0;
			cfg_seq     = '0;
			cfg_dest_hi = '0;
			cfg_dest_lo = '0;
			errors      = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			pos      = '0;
			hdr_len  = '0;
			proto_ok = 1'b0;
			type_ok  = 1'b0;
			id_ok    = 1'b1;
			seq_ok   = 1'b1;
			from_ok  = 1'b0;
		endfunction

		function void set_register(logic [2:0] idx, logic [63:0] value);
			case (idx)
				REG_FAMILY:   cfg_v6      = value[0];
				REG_IDENT:    cfg_ident   = value[15:0];
				REG_SEQUENCE: cfg_seq     = value[15:0];
				REG_DEST_HI:  cfg_dest_hi = value;
				REG_DEST_LO:  cfg_dest_lo = value;
				default: ;
			endcase
		endfunction

		function void note_byte(bit [7:0] b, bit last, bit fv6, bit [63:0] hi,
				bit [63:0] lo);
			int unsigned at;
			int unsigned off;
			bit          ok;
			at = pos;
			// Take sender and header length from the first word
			if (at == 0) begin
				clear_parse();
				if (cfg_v6)
					from_ok = fv6 && hi == cfg_dest_hi && lo == cfg_dest_lo;
				else
					from_ok = !fv6 && lo[31:0] == cfg_dest_lo[31:0];
				hdr_len = 6'(b[3:0] * IHL_UNIT);
			end
			off = cfg_v6 ? 0 : hdr_len;
			if (!cfg_v6 && at == OFS_PROTOCOL)
				proto_ok = (b == IP_PROTO_ICMP);
			if (at == off)
				type_ok = (b == (cfg_v6 ? ICMPV6_REPLY_TYPE : ICMP4_ECHO_REPLY));
			if (at == off + OFS_ID_HI && b != cfg_ident[15:8])
				id_ok = 1'b0;
			if (at == off + OFS_ID_LO && b != cfg_ident[7:0])
				id_ok = 1'b0;
			if (at == off + OFS_SEQ_HI && b != cfg_seq[15:8])
				seq_ok = 1'b0;
			if (at == off + OFS_SEQ_LO && b != cfg_seq[7:0])
				seq_ok = 1'b0;
			// Form the verdict on the last word, else advance the saturating count
			if (last) begin
				if (cfg_v6)
					ok = from_ok && at >= 7 && type_ok && id_ok && seq_ok;
				else
					ok = from_ok && proto_ok && hdr_len >= MIN_IPV4_HDR &&
						at >= hdr_len + 7 && type_ok && id_ok && seq_ok;
				verdict_q.push_back(ok);
				clear_parse();
			end else begin
				pos = 7'((at < POS_MAX) ? at + 1 : POS_MAX);
			end
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic got);
			bit want;
			if (verdict_q.size() == 0) begin
				report_mismatch($sformatf("matched=%0b with no verdict waiting", got));
			end else begin
				want = verdict_q.pop_front();
				if (got !== want)
					report_mismatch($sformatf("matched=%0b, predicted %0b", got, want));
			end
		endtask

		task finish_check();
			if (verdict_q.size() != 0)
				report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            packet_byte;
	logic                  last_byte;
	logic                  from_is_v6;
	logic [63:0]           from_addr_high;
	logic [63:0]           from_addr_low;
	logic                  out_valid;
	logic                  out_ready;
	logic                  matched;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles   = 0;
	int cycle_count   = 0;
	int bytes_sent    = 0;

	echo_reply_scoreboard sb;

	icmp_echo_reply_matcher dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.packet_byte    (packet_byte),
		.last_byte      (last_byte),
		.from_is_v6     (from_is_v6),
		.from_addr_high (from_addr_high),
		.from_addr_low  (from_addr_low),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.matched        (matched),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Abort a hung run
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_icmp_echo_reply_matcher failed");
		$finish;
	end

	// Drive result-side backpressure; hold off completely while a hold is pending
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Check every accepted result word
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(matched);
	end

	// Offer one word, with random gaps ahead of it, and hold it until accepted
	task automatic send_byte(input bit [7:0] b, input bit last, input bit fv6,
			input bit [63:0] hi, input bit [63:0] lo);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		packet_byte    <= b;
		last_byte      <= last;
		from_is_v6     <= fv6;
		from_addr_high <= hi;
		from_addr_low  <= lo;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_byte(b, last, fv6, hi, lo);
		bytes_sent++;
	endtask

	// Send a run of words; sender fields past the first word are random noise
	task automatic send_bytes(input byte_seq_t pkt, input bit fv6, input bit [63:0] hi,
			input bit [63:0] lo, input bit close);
		for (int i = 0; i < pkt.size(); i++) begin
			if (i == 0)
				send_byte(pkt[i], close && pkt.size() == 1, fv6, hi, lo);
			else
				send_byte(pkt[i], close && i == pkt.size() - 1, 1'($urandom),
					{$urandom, $urandom}, {$urandom, $urandom});
		end
	endtask

	// Drop valid and wait until every predicted result word has been taken
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_register(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Write all registers; unused upper data bits carry noise
	task automatic apply_setting(input bit v6, input bit [15:0] ident, input bit [15:0] seq,
			input bit [63:0] hi, input bit [63:0] lo);
		bit [63:0] noise;
		noise = {$urandom, $urandom};
		apb_write(REG_FAMILY, {noise[63:1], v6});
		apb_write(REG_IDENT, {noise[63:16], ident});
		apb_write(REG_SEQUENCE, {noise[47:0], seq});
		apb_write(REG_DEST_HI, hi);
		apb_write(REG_DEST_LO, lo);
	endtask

	// Build a reply for the current setting, sometimes with one flaw, or plain noise
	task automatic send_random_packet(input bit short_only);
		byte_seq_t pkt;
		bit        fv6;
		bit [63:0] fhi;
		bit [63:0] flo;
		bit [7:0]  b0;
		int        flaw;
		int        off;
		int        ihl;
		int        len;
		int        k;
		int        abit;
		fv6  = sb.cfg_v6;
		fhi  = sb.cfg_dest_hi;
		flo  = sb.cfg_dest_lo;
		ihl  = 5;
		off  = 0;
		flaw = short_only ? 20 : $urandom_range(0, 20);
		if (!fv6) begin
			// upper address bits play no part in IPv4 mode
			fhi        = {$urandom, $urandom};
			flo[63:32] = $urandom;
			if ($urandom_range(0, 3) == 0)
				ihl = $urandom_range(6, 15);
			off = ihl * IHL_UNIT;
		end
		len = off + 8;
		if ($urandom_range(0, 9) == 0)
			len += $urandom_range(60, 150);
		else
			len += $urandom_range(0, 12);
		if (flaw >= 19) begin
			len = short_only ? $urandom_range(1, 3) : $urandom_range(1, 40);
			fv6 = 1'($urandom_range(0, 1));
			fhi = {$urandom, $urandom};
			flo = {$urandom, $urandom};
		end
		for (k = 0; k < len; k++)
			pkt.push_back(8'($urandom));

		if (flaw < 19) begin
			if (sb.cfg_v6) begin
				pkt[0] = ICMPV6_REPLY_TYPE;
			end else begin
				b0 = pkt[0];
				pkt[0] = {b0[7:4], ihl[3:0]};
				pkt[OFS_PROTOCOL] = IP_PROTO_ICMP;
				pkt[off] = ICMP4_ECHO_REPLY;
			end
			pkt[off + OFS_ID_HI]  = sb.cfg_ident[15:8];
			pkt[off + OFS_ID_LO]  = sb.cfg_ident[7:0];
			pkt[off + OFS_SEQ_HI] = sb.cfg_seq[15:8];
			pkt[off + OFS_SEQ_LO] = sb.cfg_seq[7:0];

			// Inject at most one flaw
			k = $urandom_range(0, 7);
			case (flaw)
				11: pkt[off] = pkt[off] ^ (8'd1 << k);
				12: pkt[off + OFS_ID_HI + k % 2] =
					pkt[off + OFS_ID_HI + k % 2] ^ (8'd1 << k);
				13: pkt[off + OFS_SEQ_HI + k % 2] =
					pkt[off + OFS_SEQ_HI + k % 2] ^ (8'd1 << k);
				14: begin
					len = $urandom_range(1, off + 7);
					pkt = pkt[0:len-1];
				end
				15: begin
					abit = $urandom_range(0, 63);
					if (fv6 && abit[0])
						fhi[abit] = ~fhi[abit];
					else if (fv6)
						flo[abit] = ~flo[abit];
					else
						flo[abit % 32] = ~flo[abit % 32];
				end
				16: fv6 = ~fv6;
				17: begin
					if (sb.cfg_v6)
						pkt[0] = ICMP4_ECHO_REPLY;
					else
						pkt[OFS_PROTOCOL] = pkt[OFS_PROTOCOL] ^ (8'd1 << k);
				end
				18: begin
					b0 = pkt[0];
					if (sb.cfg_v6)
						pkt[0] = 8'd128;
					else
						pkt[0] = {b0[7:4], 4'($urandom_range(0, 4))};
				end
				default: ;
			endcase
		end
		send_bytes(pkt, fv6, fhi, flo, 1'b1);
	endtask

	initial begin
		byte_seq_t pkt;
		int        target;
		sb             = new();
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		packet_byte    = '0;
		last_byte      = 1'b0;
		from_is_v6     = 1'b0;
		from_addr_high = '0;
		from_addr_low  = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: clean ICMPv6 reply, lone word, wrong family, register change mid-packet
		apply_setting(1'b1, 16'hFFFF, 16'h0000, '1, '1);
		pkt = '{ICMPV6_REPLY_TYPE, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
		send_bytes(pkt, 1'b1, '1, '1, 1'b1);
		pkt = '{8'h00};
		send_bytes(pkt, 1'b1, '1, '1, 1'b1);
		pkt = '{ICMPV6_REPLY_TYPE, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
		send_bytes(pkt, 1'b0, '1, '1, 1'b1);
		pkt = '{ICMPV6_REPLY_TYPE, 8'h00, 8'h00, 8'h00};
		send_bytes(pkt, 1'b1, '1, '1, 1'b0);
		drain();
		apb_write(REG_SEQUENCE, 64'h5AA5);
		pkt = '{8'hFF, 8'hFF, 8'h5A, 8'hA5};
		send_bytes(pkt, 1'b1, '1, '1, 1'b1);

		// Random: three idle profiles, each with an extreme and a random setting
		target = bytes_sent;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 46 : 0;
			recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 21 : 0;
			for (int st = 0; st < 2; st++) begin
				drain();
				if (st == 0) begin
					case (ph)
						0: apply_setting(1'b0, 16'h0000, 16'h0000, '0, '0);
						1: apply_setting(1'b1, 16'hFFFF, 16'hFFFF, '1, '1);
						default: apply_setting(1'b0, 16'hFFFF, 16'h0000, '1,
							64'h0000_0000_FFFF_FFFF);
					endcase
				end else begin
					apply_setting(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
						{$urandom, $urandom}, {$urandom, $urandom});
				end
				target += RANDOM_BYTES / 6;
				while (bytes_sent < target)
					send_random_packet(1'b0);
			end
		end

		// Hold off the result side while short packets keep coming, so input stalls
		hold_cycles = HOLD_CYCLES;
		repeat (40) send_random_packet(1'b1);

		drain();
		sb.finish_check();
		if (sb.errors == 0)
			$display("tb_icmp_echo_reply_matcher passed");
		else
			$display("tb_icmp_echo_reply_matcher failed");
		$finish;
	end

endmodule

### sim.f
hdl/iem_pkg.sv
hdl/icmp_echo_reply_matcher.sv
dv/tb_icmp_echo_reply_matcher.sv
